// ----- rtl/core/watering_valve_pump_sequencer_top_macros.svh -----
// ----------------------------------------------------------------------------
// Watering valve pump sequencer assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WATERING_VALVE_PUMP_SEQUENCER_TOP_MACROS_SVH
`define WATERING_VALVE_PUMP_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define WVPS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Expression must never be true.
`define WVPS_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define WVPS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define WVPS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- rtl/core/wvps_pkg.sv -----
// ----------------------------------------------------------------------------
// Watering valve pump sequencer package
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wvps_pkg;

    localparam int POT_COUNT = 4;

    localparam int DIVIDEND_W = 40;
    localparam int DIVISOR_W  = 32;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // Configuration register indexes.
    localparam logic [2:0] CFG_LOW_TEMP  = 3'd0;
    localparam logic [2:0] CFG_HIGH_TEMP = 3'd1;
    localparam logic [2:0] CFG_FLOW      = 3'd2;
    localparam logic [2:0] CFG_SETTLE    = 3'd3;
    localparam logic [2:0] CFG_TPS       = 3'd4;

    typedef struct packed {
        logic load;
        logic prod;
        logic dstart;
        logic dfix;
        logic mul;
        logic rstart;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_dose;
        logic div_done;
    } sts_t;

endpackage

// ----- rtl/core/wvps_div.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvps_div
    import wvps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder,
    output logic                  done
);

    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]  r_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic                  ge;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        shifted = {r_reg, q_reg[DIVIDEND_W-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            q_reg    <= dividend;
            r_reg    <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            q_reg <= {q_reg[DIVIDEND_W-2:0], ge};
            r_reg <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = done_reg;

endmodule

// ----- rtl/core/wvps_datapath.sv -----
// ----------------------------------------------------------------------------
// Sequencer datapath
// Holds configuration, the watering sequence state, timers and dose math.
// ----------------------------------------------------------------------------
module wvps_datapath
    import wvps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [71:0] in_data,
    output logic [31:0] out_data
);

    typedef enum logic [3:0] {
        SQ_IDLE        = 4'd0,
        SQ_CHECK_START = 4'd1,
        SQ_START       = 4'd2,
        SQ_START_TIMER = 4'd3,
        SQ_EN_VALVE    = 4'd4,
        SQ_WAIT_VALVE  = 4'd5,
        SQ_EN_PUMP     = 4'd6,
        SQ_CHECK_STOP  = 4'd7,
        SQ_STOP        = 4'd8,
        SQ_DIS_PUMP    = 4'd9,
        SQ_WAIT_PUMP   = 4'd10,
        SQ_DIS_VALVES  = 4'd11,
        SQ_POST        = 4'd12,
        SQ_RESET       = 4'd13
    } seq_t;

    // Configuration.
    logic signed [11:0] lo_reg, hi_reg;
    logic [15:0]        flow_reg, settle_reg, tps_reg;

    // Latched input item.
    logic               req_reg, valid_reg;
    logic [1:0]         pot_reg;
    logic signed [11:0] temp_reg;
    logic [15:0]        mn_reg, mx_reg, corr_reg;

    // Sequence state.
    seq_t        seq_reg, seq_next;
    logic [3:0]  valve_reg;
    logic        pump_reg, run_active_reg;
    logic [31:0] run_left_reg;
    logic [15:0] wait_left_reg;
    logic [15:0] dose_reg;
    logic        dv_reg, clrpot_reg, clrreq_reg;

    // Arithmetic intermediates.
    logic signed [29:0] prod_reg;
    logic [15:0]        new_dose_reg;
    logic [39:0]        num_reg;
    logic [31:0]        den_reg;

    logic signed [12:0] diff_t, diff_pt;
    logic signed [16:0] diff_d;
    logic [29:0]        prod_abs;
    logic [12:0]        pt_abs;
    logic               neg;
    logic [30:0]        mag;
    logic signed [31:0] qf, sum, mn_s, mx_s;
    logic [15:0]        dose_calc;
    logic [40:0]        run_sum;
    logic [31:0]        run_val;

    logic               div_start;
    logic [39:0]        div_dividend, quotient;
    logic [31:0]        div_divisor, remainder;
    logic               div_done;

    always_comb begin
        diff_t   = 13'(temp_reg) - 13'(lo_reg);
        diff_pt  = 13'(hi_reg) - 13'(lo_reg);
        diff_d   = $signed({1'b0, mx_reg}) - $signed({1'b0, mn_reg});
        prod_abs = prod_reg[29] ? 30'(-prod_reg) : 30'(prod_reg);
        pt_abs   = diff_pt[12] ? 13'(-diff_pt) : 13'(diff_pt);
        neg      = prod_reg[29] ^ diff_pt[12];
        // Floor division: a negative quotient with a remainder drops one more.
        mag      = {1'b0, quotient[29:0]} + 31'(neg && (remainder != '0));
        qf       = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        mn_s     = $signed({16'd0, mn_reg});
        mx_s     = $signed({16'd0, mx_reg});
        sum      = mn_s + qf;
        if (lo_reg == hi_reg) begin
            dose_calc = (temp_reg >= lo_reg) ? mx_reg : mn_reg;
        end else if (sum < mn_s) begin
            dose_calc = mn_reg;
        end else if (sum > mx_s) begin
            dose_calc = mx_reg;
        end else begin
            dose_calc = sum[15:0];
        end
        run_sum = {1'b0, quotient} + 41'(settle_reg);
        if (den_reg == '0 || run_sum[40:32] != '0) begin
            run_val = '1;
        end else begin
            run_val = run_sum[31:0];
        end
    end

    assign div_start    = cmd.dstart || cmd.rstart;
    assign div_dividend = cmd.dstart ? {10'd0, prod_abs} : num_reg;
    assign div_divisor  = cmd.dstart ? {19'd0, pt_abs} : den_reg;

    wvps_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quotient),
        .remainder (remainder),
        .done      (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg     <= 12'sd100;
            hi_reg     <= 12'sd300;
            flow_reg   <= 16'd30;
            settle_reg <= 16'd2000;
            tps_reg    <= 16'd1000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOW_TEMP:  lo_reg     <= cfg_data[11:0];
                CFG_HIGH_TEMP: hi_reg     <= cfg_data[11:0];
                CFG_FLOW:      flow_reg   <= cfg_data;
                CFG_SETTLE:    settle_reg <= cfg_data;
                CFG_TPS:       tps_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Payload registers for the arithmetic need no reset.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= in_data[1];
            valid_reg <= in_data[2];
            pot_reg   <= in_data[4:3];
            temp_reg  <= in_data[16:5];
            mn_reg    <= in_data[32:17];
            mx_reg    <= in_data[48:33];
            corr_reg  <= in_data[64:49];
        end
        if (cmd.prod) begin
            prod_reg <= diff_t * diff_d;
        end
        if (cmd.dfix) begin
            new_dose_reg <= dose_calc;
        end
        if (cmd.mul) begin
            num_reg <= {32'(new_dose_reg) * 32'(tps_reg), 8'd0};
            den_reg <= flow_reg * corr_reg;
        end
    end

    always_comb begin
        seq_next = SQ_IDLE;
        case (seq_reg)
            SQ_IDLE:        seq_next = SQ_CHECK_START;
            SQ_CHECK_START: seq_next = (req_reg && valid_reg) ? SQ_START : SQ_CHECK_START;
            SQ_START:       seq_next = SQ_START_TIMER;
            SQ_START_TIMER: seq_next = valid_reg ? SQ_EN_VALVE : SQ_STOP;
            SQ_EN_VALVE:    seq_next = valid_reg ? SQ_WAIT_VALVE : SQ_STOP;
            SQ_WAIT_VALVE:  seq_next = (wait_left_reg == '0) ? SQ_EN_PUMP : SQ_WAIT_VALVE;
            SQ_EN_PUMP:     seq_next = SQ_CHECK_STOP;
            SQ_CHECK_STOP:  seq_next = (!req_reg || (run_active_reg && run_left_reg == '0))
                                       ? SQ_STOP : SQ_CHECK_STOP;
            SQ_STOP:        seq_next = SQ_DIS_PUMP;
            SQ_DIS_PUMP:    seq_next = SQ_WAIT_PUMP;
            SQ_WAIT_PUMP:   seq_next = (wait_left_reg == '0) ? SQ_DIS_VALVES : SQ_WAIT_PUMP;
            SQ_DIS_VALVES:  seq_next = SQ_POST;
            SQ_POST:        seq_next = SQ_RESET;
            SQ_RESET:       seq_next = SQ_IDLE;
            default:        seq_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= SQ_IDLE;
            valve_reg      <= '0;
            pump_reg       <= 1'b0;
            run_left_reg   <= '0;
            run_active_reg <= 1'b0;
            wait_left_reg  <= '0;
            dose_reg       <= '0;
            dv_reg         <= 1'b0;
            clrpot_reg     <= 1'b0;
            clrreq_reg     <= 1'b0;
        end else if (cmd.load) begin
            if (in_data[0]) begin
                if (wait_left_reg != '0) begin
                    wait_left_reg <= wait_left_reg - 1'b1;
                end
                if (run_active_reg && run_left_reg != '0) begin
                    run_left_reg <= run_left_reg - 1'b1;
                end
            end
        end else if (cmd.commit) begin
            seq_reg    <= seq_next;
            dv_reg     <= (seq_reg == SQ_START_TIMER) && valid_reg;
            clrpot_reg <= (seq_reg == SQ_POST) && valid_reg;
            clrreq_reg <= (seq_reg == SQ_RESET);
            case (seq_reg)
                SQ_START_TIMER: begin
                    if (valid_reg) begin
                        dose_reg       <= new_dose_reg;
                        run_left_reg   <= run_val;
                        run_active_reg <= 1'b1;
                    end
                end
                SQ_EN_VALVE: begin
                    if (valid_reg) begin
                        if (int'(pot_reg) < POT_COUNT) begin
                            valve_reg[pot_reg] <= 1'b1;
                        end
                        wait_left_reg <= settle_reg;
                    end
                end
                SQ_EN_PUMP:    pump_reg       <= 1'b1;
                SQ_STOP:       run_active_reg <= 1'b0;
                SQ_DIS_PUMP: begin
                    pump_reg      <= 1'b0;
                    wait_left_reg <= settle_reg;
                end
                SQ_DIS_VALVES: valve_reg <= '0;
                default: ;
            endcase
        end
    end

    assign sts.need_dose = (seq_reg == SQ_START_TIMER) && valid_reg;
    assign sts.div_done  = div_done;

    assign out_data = {3'd0, run_active_reg, clrreq_reg, clrpot_reg, dv_reg,
                       dose_reg, seq_reg, pump_reg, valve_reg};

endmodule

// ----- rtl/core/wvps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sequencer controller
// Steps each item through load, dose and run division when due, and delivery.
// ----------------------------------------------------------------------------
module wvps_ctrl
    import wvps_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        C_IDLE,
        C_PROD,
        C_DSTART,
        C_DWAIT,
        C_DFIX,
        C_MUL,
        C_RSTART,
        C_RWAIT,
        C_COMMIT,
        C_OUT
    } ctrl_t;

    ctrl_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            case (state_reg)
                C_IDLE:   if (s_tvalid) state_reg <= C_PROD;
                C_PROD:   state_reg <= sts.need_dose ? C_DSTART : C_COMMIT;
                C_DSTART: state_reg <= C_DWAIT;
                C_DWAIT:  if (sts.div_done) state_reg <= C_DFIX;
                C_DFIX:   state_reg <= C_MUL;
                C_MUL:    state_reg <= C_RSTART;
                C_RSTART: state_reg <= C_RWAIT;
                C_RWAIT:  if (sts.div_done) state_reg <= C_COMMIT;
                C_COMMIT: state_reg <= C_OUT;
                C_OUT:    if (m_tready) state_reg <= C_IDLE;
                default:  state_reg <= C_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == C_IDLE);
    assign m_tvalid   = (state_reg == C_OUT);
    assign cmd.load   = s_tready && s_tvalid;
    assign cmd.prod   = (state_reg == C_PROD);
    assign cmd.dstart = (state_reg == C_DSTART);
    assign cmd.dfix   = (state_reg == C_DFIX);
    assign cmd.mul    = (state_reg == C_MUL);
    assign cmd.rstart = (state_reg == C_RSTART);
    assign cmd.commit = (state_reg == C_COMMIT);

endmodule

// ----- rtl/core/watering_valve_pump_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// Watering valve pump sequencer
// Each input transfer is one control pass of the valve and pump sequence; each
// pass returns exactly one result transfer with outputs and pulses.
// Channels: s_* carries the control pass, m_* the result, and the cfg_* port
// writes the five configuration registers (index 0 low temperature point,
// 1 high temperature point, 2 pump flow rate, 3 settle wait, 4 ticks per second).
// A pass that does not compute a dose goes from the product step straight to
// commit and output. The pass that computes the dose runs two 40-step serial
// divisions on the shared divider, first for the dose and then for the run
// time, before commit and output. That divider sets the throughput.
// One item is worked on at a time: s_tready is high only while the block is
// empty, and rises again the cycle after the result transfer completes.
// When the receiver stalls, the result stays in the output register and no
// new input is taken until m_tready is seen high.
// Reset (aresetn low, synchronous) returns the sequence to idle, closes all
// valves, turns the pump off, clears the timers and the held dose, and loads
// the configuration reset values.
// ----------------------------------------------------------------------------
`include "watering_valve_pump_sequencer_top_macros.svh"

module watering_valve_pump_sequencer_top
    import wvps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input channel. tdata from bit 0 up: time_tick, request_watering,
    // settings_valid, pot_index[1:0], temperature[11:0], min_dose_ml[15:0],
    // max_dose_ml[15:0], flow_correction[15:0], zero fill.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    // Result channel. tdata from bit 0 up: valve_open_mask[3:0], pump_on,
    // sequence_state[3:0], dose_ml[15:0], dose_valid, clear_pot_flag,
    // clear_request, watering_active, zero fill.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    // The controller sequences the steps; the datapath does all arithmetic.
    wvps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wvps_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

    // Only one item is in flight, so input and output are never open together.
    `WVPS_ASSERT_NEVER(a_one_in_flight, aclk, aresetn, s_tready && m_tvalid)
    // A fresh dose is only reported on the step that enters the enable valve state.
    `WVPS_ASSERT_IMPLIES(a_dose_state, aclk, aresetn, m_tvalid && m_tdata[25],
                         m_tdata[8:5] == 4'd4)
    // The request clear pulse comes with the return to idle.
    `WVPS_ASSERT_IMPLIES(a_clear_idle, aclk, aresetn, m_tvalid && m_tdata[27],
                         m_tdata[8:5] == 4'd0)
    // The pump only runs with a valve open.
    `WVPS_ASSERT_IMPLIES(a_pump_valve, aclk, aresetn, m_tvalid && m_tdata[4],
                         m_tdata[3:0] != 4'd0)

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Watering sequencer testbench
// Sends control passes into the sequencer over the input stream and checks
// every result transfer against a cycle-free model of the fourteen-state valve
// and pump sequence, or a typed-in result. A directed table starts the run, and
// random passes follow under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import wvps_pkg::*;

    // Sequence state codes as they appear in the result.
    typedef enum logic [3:0] {
        SEQ_IDLE = 4'd0, SEQ_CHECK_START = 4'd1, SEQ_START = 4'd2,
        SEQ_START_TIMER = 4'd3, SEQ_ENABLE_VALVE = 4'd4, SEQ_WAIT_VALVE = 4'd5,
        SEQ_ENABLE_PUMP = 4'd6, SEQ_CHECK_STOP = 4'd7, SEQ_STOP = 4'd8,
        SEQ_DISABLE_PUMP = 4'd9, SEQ_WAIT_PUMP = 4'd10, SEQ_DISABLE_VALVES = 4'd11,
        SEQ_POST = 4'd12, SEQ_RESET = 4'd13
    } seq_e;

    // One control pass, packed as on s_tdata (last member in the lowest bits).
    typedef struct packed {
        logic [6:0]  fill;
        logic [15:0] flow_correction;
        logic [15:0] max_dose_ml;
        logic [15:0] min_dose_ml;
        logic [11:0] temperature;
        logic [1:0]  pot_index;
        logic        settings_valid;
        logic        request_watering;
        logic        time_tick;
    } pass_t;

    // One result, packed as on m_tdata[28:0].
    typedef struct packed {
        logic        watering_active;
        logic        clear_request;
        logic        clear_pot_flag;
        logic        dose_valid;
        logic [15:0] dose_ml;
        logic [3:0]  sequence_state;
        logic        pump_on;
        logic [3:0]  valve_open_mask;
    } status_t;

    // A row of the directed table: the pass, and a typed-in result where one
    // can be read off directly.
    typedef struct {
        pass_t   pass;
        bit      typed;
        status_t status;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 373;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_LOW_TEMP;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    always #4 aclk = ~aclk;

    watering_valve_pump_sequencer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Model copy of the configuration registers.
    logic signed [11:0] low_point;
    logic signed [11:0] high_point;
    logic [15:0]        flow_rate;
    logic [15:0]        settle_ticks;
    logic [15:0]        tick_rate;

    // Model copy of the sequence state.
    seq_e        seq;
    logic [3:0]  valves;
    logic        pump;
    logic [31:0] run_left;
    logic        run_active;
    logic [31:0] wait_left;
    logic [15:0] held_dose;

    status_t pending_status[$];
    int      errors = 0;
    int      sender_idle = 0;
    int      receiver_idle = 0;
    bit      long_stall_req = 0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0)))
            q--;
        return q;
    endfunction

    // Dose as a linear map of temperature between the two points, clamped to
    // the pot's limits. Equal points make it a step at the low point.
    function automatic logic [15:0] dose_for(longint t, longint mn, longint mx);
        longint lo, hi, q;
        lo = low_point;
        hi = high_point;
        if (lo == hi)
            return (t >= lo) ? mx[15:0] : mn[15:0];
        q = mn + floor_quot((t - lo) * (mx - mn), hi - lo);
        if (q < mn)
            q = mn;
        else if (q > mx)
            q = mx;
        return q[15:0];
    endfunction

    // Pump run ticks, saturated; a zero divisor runs until the request drops.
    function automatic logic [31:0] run_ticks_for(logic [15:0] dose, logic [15:0] corr);
        longint unsigned num, den, r;
        num = longint'(dose) * longint'(tick_rate) * 256;
        den = longint'(flow_rate) * longint'(corr);
        if (den == 0)
            return 32'hFFFF_FFFF;
        r = num / den + longint'(settle_ticks);
        if (r > 64'hFFFF_FFFF)
            r = 64'hFFFF_FFFF;
        return r[31:0];
    endfunction

    function automatic void reset_sequencer_model();
        low_point = 12'sd100;
        high_point = 12'sd300;
        flow_rate = 16'd30;
        settle_ticks = 16'd2000;
        tick_rate = 16'd1000;
        seq = SEQ_IDLE;
        valves = '0;
        pump = 1'b0;
        run_left = '0;
        run_active = 1'b0;
        wait_left = '0;
        held_dose = '0;
    endfunction

    // Advances the model by one control pass and returns its result.
    function automatic status_t step_sequencer(pass_t p);
        status_t r;
        r = '0;
        if (p.time_tick) begin
            if (wait_left != 0)
                wait_left--;
            if (run_active && run_left != 0)
                run_left--;
        end
        case (seq)
            SEQ_IDLE: seq = SEQ_CHECK_START;
            SEQ_CHECK_START: if (p.request_watering && p.settings_valid) seq = SEQ_START;
            SEQ_START: seq = SEQ_START_TIMER;
            SEQ_START_TIMER: begin
                if (p.settings_valid) begin
                    held_dose = dose_for(longint'($signed(p.temperature)),
                                         longint'(p.min_dose_ml), longint'(p.max_dose_ml));
                    r.dose_valid = 1'b1;
                    run_left = run_ticks_for(held_dose, p.flow_correction);
                    run_active = 1'b1;
                    seq = SEQ_ENABLE_VALVE;
                end else begin
                    seq = SEQ_STOP;
                end
            end
            SEQ_ENABLE_VALVE: begin
                if (p.settings_valid) begin
                    if (p.pot_index < POT_COUNT)
                        valves[p.pot_index] = 1'b1;
                    wait_left = settle_ticks;
                    seq = SEQ_WAIT_VALVE;
                end else begin
                    seq = SEQ_STOP;
                end
            end
            SEQ_WAIT_VALVE: if (wait_left == 0) seq = SEQ_ENABLE_PUMP;
            SEQ_ENABLE_PUMP: begin
                pump = 1'b1;
                seq = SEQ_CHECK_STOP;
            end
            SEQ_CHECK_STOP:
                if (!p.request_watering || (run_active && run_left == 0)) seq = SEQ_STOP;
            SEQ_STOP: begin
                run_active = 1'b0;
                seq = SEQ_DISABLE_PUMP;
            end
            SEQ_DISABLE_PUMP: begin
                pump = 1'b0;
                wait_left = settle_ticks;
                seq = SEQ_WAIT_PUMP;
            end
            SEQ_WAIT_PUMP: if (wait_left == 0) seq = SEQ_DISABLE_VALVES;
            SEQ_DISABLE_VALVES: begin
                valves = '0;
                seq = SEQ_POST;
            end
            SEQ_POST: begin
                r.clear_pot_flag = p.settings_valid;
                seq = SEQ_RESET;
            end
            SEQ_RESET: begin
                r.clear_request = 1'b1;
                seq = SEQ_IDLE;
            end
            default: seq = SEQ_IDLE;
        endcase
        r.valve_open_mask = valves;
        r.pump_on = pump;
        r.sequence_state = seq;
        r.dose_ml = held_dose;
        r.watering_active = run_active;
        return r;
    endfunction

    // Directed table; typed rows hold the obvious results.
    row_t directed[$];

    function automatic pass_t make_pass(bit tick, bit req, bit valid, int pot, int temp,
                                        int mn, int mx, int corr);
        pass_t p;
        p = '0;
        p.time_tick = tick;
        p.request_watering = req;
        p.settings_valid = valid;
        p.pot_index = pot[1:0];
        p.temperature = temp[11:0];
        p.min_dose_ml = mn[15:0];
        p.max_dose_ml = mx[15:0];
        p.flow_correction = corr[15:0];
        return p;
    endfunction

    function automatic void add_row(pass_t p, bit typed = 0, status_t s = '0);
        row_t r;
        r.pass = p;
        r.typed = typed;
        r.status = s;
        directed.push_back(r);
    endfunction

    function automatic status_t seen_status(seq_e st, int mask, int dose, bit dv, bit act);
        status_t s;
        s = '0;
        s.sequence_state = st;
        s.valve_open_mask = mask[3:0];
        s.dose_ml = dose[15:0];
        s.dose_valid = dv;
        s.watering_active = act;
        return s;
    endfunction

    function automatic void build_directed();
        // Leaving idle, then waiting on a missing request or invalid settings.
        add_row(make_pass(0, 0, 0, 0, 0, 0, 0, 1), 1, seen_status(SEQ_CHECK_START, 0, 0, 0, 0));
        add_row(make_pass(1, 0, 1, 0, 0, 0, 0, 1), 1, seen_status(SEQ_CHECK_START, 0, 0, 0, 0));
        add_row(make_pass(0, 1, 0, 0, 0, 0, 0, 1), 1, seen_status(SEQ_CHECK_START, 0, 0, 0, 0));
        add_row(make_pass(0, 1, 1, 3, 0, 0, 0, 1), 1, seen_status(SEQ_START, 0, 0, 0, 0));
        add_row(make_pass(0, 1, 1, 3, 1250, 10, 500, 256), 1,
                seen_status(SEQ_START_TIMER, 0, 0, 0, 0));
        // Hottest temperature clamps the dose to the upper limit.
        add_row(make_pass(0, 1, 1, 3, 1250, 10, 500, 256), 1,
                seen_status(SEQ_ENABLE_VALVE, 0, 500, 1, 1));
        add_row(make_pass(0, 1, 1, 3, 1250, 10, 500, 256), 1,
                seen_status(SEQ_WAIT_VALVE, 8, 500, 0, 1));
        add_row(make_pass(1, 1, 1, 3, 0, 0, 0, 1));
        add_row(make_pass(0, 1, 1, 3, 0, 0, 0, 1));
        // Withdrawn request stops the pump.
        add_row(make_pass(1, 0, 1, 3, 0, 0, 0, 1));
        add_row(make_pass(0, 0, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(0, 0, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(1, 0, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(0, 0, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(0, 0, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(0, 0, 1, 0, 0, 0, 0, 1));
        // Second cycle: coldest temperature, inverted limits, zero correction,
        // and settings lost when the valve should open.
        add_row(make_pass(0, 1, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(0, 1, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(0, 1, 1, 0, 0, 0, 0, 1));
        add_row(make_pass(1, 1, 1, 1, -400, 65535, 0, 0));
        add_row(make_pass(0, 1, 0, 1, 0, 0, 0, 0));
        add_row(make_pass(0, 1, 0, 2, 0, 0, 0, 0));
        add_row(make_pass(1, 1, 0, 2, 0, 0, 0, 0));
        add_row(make_pass(1, 1, 0, 2, 0, 0, 0, 0));
        add_row(make_pass(0, 1, 0, 2, 0, 0, 0, 0));
    endfunction

    function automatic pass_t random_pass();
        pass_t p;
        p = '0;
        p.time_tick = ($urandom_range(99) < 60);
        p.request_watering = ($urandom_range(99) < 85);
        p.settings_valid = ($urandom_range(99) < 92);
        p.pot_index = 2'($urandom_range(3));
        if ($urandom_range(7) == 0)
            p.temperature = 12'($urandom);
        else
            p.temperature = 12'($urandom_range(1650) - 400);
        p.min_dose_ml = 16'($urandom);
        p.max_dose_ml = 16'($urandom);
        case ($urandom_range(19))
            0: p.flow_correction = '0;
            1, 2, 3: p.flow_correction = 16'd256;
            default: p.flow_correction = 16'($urandom);
        endcase
        return p;
    endfunction

    // Writes one register; the model follows at once.
    task automatic write_register(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_LOW_TEMP:  low_point = val[11:0];
            CFG_HIGH_TEMP: high_point = val[11:0];
            CFG_FLOW:      flow_rate = val;
            CFG_SETTLE:    settle_ticks = val;
            CFG_TPS:       tick_rate = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(int lo, int hi, int flow, int settle, int tps);
        write_register(CFG_LOW_TEMP, 16'(lo));
        write_register(CFG_HIGH_TEMP, 16'(hi));
        write_register(CFG_FLOW, 16'(flow));
        write_register(CFG_SETTLE, 16'(settle));
        write_register(CFG_TPS, 16'(tps));
        cfg_we <= 1'b0;
    endtask

    // Offers one pass, idling first at the sender's rate, and returns once the
    // transfer has completed. tvalid stays high for a back-to-back pass.
    task automatic send_pass(pass_t p);
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        while (pending_status.size() != 0)
            @(posedge aclk);
    endtask

    // Every accepted pass is run through the model at the edge that takes it;
    // typed rows replace the model's result with the one written in the table.
    bit      typed_next = 0;
    status_t typed_status;

    always @(posedge aclk) begin
        status_t predicted;
        if (aresetn && s_tvalid && s_tready) begin
            predicted = step_sequencer(s_tdata);
            pending_status.push_back(typed_next ? typed_status : predicted);
        end
    end

    function automatic void check_field(string name, int e, int a);
        if (e != a) begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        status_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[28:0];
            if (pending_status.size() == 0) begin
                $display("%0t: result with nothing expected: actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_status.pop_front();
                check_field("valve_open_mask", want.valve_open_mask, got.valve_open_mask);
                check_field("pump_on", want.pump_on, got.pump_on);
                check_field("sequence_state", want.sequence_state, got.sequence_state);
                check_field("dose_ml", want.dose_ml, got.dose_ml);
                check_field("dose_valid", want.dose_valid, got.dose_valid);
                check_field("clear_pot_flag", want.clear_pot_flag, got.clear_pot_flag);
                check_field("clear_request", want.clear_request, got.clear_request);
                check_field("watering_active", want.watering_active, got.watering_active);
                check_field("zero fill", 0, m_tdata[31:29]);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (long_stall_req) begin
            long_stall_req = 0;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        reset_sequencer_model();
        build_directed();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with a short settle wait so the sequence gets around.
        // The row's expectation changes only after the previous row's edge.
        apply_settings(100, 300, 30, 1, 1000);
        foreach (directed[i]) begin
            typed_next <= directed[i].typed;
            typed_status <= directed[i].status;
            send_pass(directed[i].pass);
        end
        typed_next <= 1'b0;
        s_tvalid <= 1'b0;
        drain();

        // Random phases: register settings including the extremes, with the
        // idling pattern changing every two phases.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            repeat (8) @(posedge aclk);
            case (ph)
                0: apply_settings(100, 300, 30, 3, 10);
                1: apply_settings(-400, 1250, 1, 0, 65535);
                2: apply_settings(200, 200, 65535, 5, 1);
                3: apply_settings(1250, -400, 7, 65535, 1000);
                4: apply_settings(-400, -400, 65535, 2, 65535);
                default: apply_settings(0, 1250, 1, 1, 1);
            endcase
            case (ph / 2)
                0: begin sender_idle = 27; receiver_idle = 56; end
                1: begin sender_idle = 56; receiver_idle = 27; end
                default: begin sender_idle = 0; receiver_idle = 0; end
            endcase
            if (ph == 1)
                long_stall_req = 1;
            for (int n = 0; n < (ph == 3 ? 60 : PHASE_ITEMS); n++)
                send_pass(random_pass());
            s_tvalid <= 1'b0;
        end

        drain();
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/wvps_pkg.sv
rtl/core/wvps_div.sv
rtl/core/wvps_datapath.sv
rtl/core/wvps_ctrl.sv
rtl/core/watering_valve_pump_sequencer_top.sv
tb/sv/tb_top.sv
